### rtl/core/bba_pkg.sv
package bba_pkg;

    localparam int ADDR_W    = 48;
    localparam int BYTES_W   = 32;
    localparam int SIZE_W    = 21;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 1;
    localparam int ORD_W     = 6;
    localparam int TOP_W     = 5;
    localparam int STAT_W    = 2;

    localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STAT_W-1:0] ST_REFUSED  = 2'd1;
    localparam logic [STAT_W-1:0] ST_IGNORED  = 2'd2;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BYTES = 1'd1;

    localparam logic [0:0] OP_ALLOC = 1'b0;
    localparam logic [0:0] OP_FREE  = 1'b1;

endpackage

### rtl/core/bba_req_if.sv
interface bba_req_if
    import bba_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [BYTES_W-1:0] request_bytes;
    logic [ADDR_W-1:0]  block_address;

    modport source (output valid, output opcode, output request_bytes, output block_address,
                    input ready);
    modport sink   (input valid, input opcode, input request_bytes, input block_address,
                    output ready);
endinterface

### rtl/core/bba_rsp_if.sv
interface bba_rsp_if
    import bba_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] granted_address;

    modport source (output valid, output status, output granted_address, input ready);
    modport sink   (input valid, input status, input granted_address, output ready);
endinterface

### rtl/core/bba_store.sv
module bba_store #(
    parameter int AW = 15,
    parameter int DW = 14
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/buddy_block_allocator_unit.sv
// Allocate: check, scan upwards through the orders, pop a block, read its index,
// then push one split half per order down to the wanted order. Free: check, then
// per order tried, seek the buddy and shift later entries over it; then push.
// One item in flight; the next is accepted while a result waits at the output.
// rst_n asynchronous: counts seeded with one block at the top order, then S_INIT
// writes that seed entry; the stack memory itself is not cleared.
module buddy_block_allocator_unit
    import bba_pkg::*;
#(
    parameter int REGION_ORDER = 20,
    parameter int MIN_ORDER    = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    bba_req_if.sink              req,
    bba_rsp_if.source            rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int IDX_W   = (REGION_ORDER > MIN_ORDER) ? REGION_ORDER - MIN_ORDER : 1;
    localparam int AW      = IDX_W + 1;
    localparam int CW      = IDX_W + 1;
    localparam int NORD    = REGION_ORDER + 1;
    localparam int OW      = $clog2(NORD);
    localparam int TOP_RST = (REGION_ORDER < 20) ? REGION_ORDER : 20;
    localparam logic [ADDR_W-1:0] LOW_MASK = ADDR_W'((64'd1 << MIN_ORDER) - 64'd1);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_START  = 4'd2;
    localparam logic [3:0] S_ASCAN  = 4'd3;
    localparam logic [3:0] S_APOP   = 4'd4;
    localparam logic [3:0] S_AGET   = 4'd5;
    localparam logic [3:0] S_ASPLIT = 4'd6;
    localparam logic [3:0] S_FCHK   = 4'd7;
    localparam logic [3:0] S_FSRCH  = 4'd8;
    localparam logic [3:0] S_FCMP   = 4'd9;
    localparam logic [3:0] S_FSHR   = 4'd10;
    localparam logic [3:0] S_FSHW   = 4'd11;
    localparam logic [3:0] S_FEND   = 4'd12;
    localparam logic [3:0] S_DONE   = 4'd13;

    function automatic logic [ORD_W-1:0] order_of(input logic [BYTES_W-1:0] b);
        logic [BYTES_W-1:0] m;
        logic [ORD_W-1:0]   c;
        m = b - BYTES_W'(1);
        c = '0;
        for (int i = 0; i < BYTES_W; i++)
        begin
            if (m[i])
            begin
                c = ORD_W'(i + 1);
            end
        end
        if (c < ORD_W'(MIN_ORDER))
        begin
            c = ORD_W'(MIN_ORDER);
        end
        return c;
    endfunction

    function automatic logic [TOP_W-1:0] floor_log2(input logic [SIZE_W-1:0] v);
        logic [TOP_W-1:0] k;
        k = '0;
        for (int i = 0; i < SIZE_W; i++)
        begin
            if (v[i])
            begin
                k = TOP_W'(i);
            end
        end
        if (k > TOP_W'(REGION_ORDER))
        begin
            k = TOP_W'(REGION_ORDER);
        end
        return k;
    endfunction

    // start of an order's slice in the stack memory
    function automatic logic [AW-1:0] slice_of(input logic [ORD_W-1:0] k);
        logic [AW:0] span;
        span = (AW+1)'(1) << (ORD_W'(REGION_ORDER + 1) - k);
        return AW'((AW+1)'(2**AW) - span);
    endfunction

    function automatic logic [CW:0] cap_of(input logic [ORD_W-1:0] k);
        return (CW+1)'(1) << (ORD_W'(REGION_ORDER) - k);
    endfunction

    logic [3:0]         state_reg, state_next;
    logic               op_reg, op_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [ORD_W-1:0]   want_reg, want_next;
    logic [ORD_W-1:0]   ord_reg, ord_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CW-1:0]      ptr_reg, ptr_next;
    logic [STAT_W-1:0]  res_status_reg, res_status_next;
    logic [ADDR_W-1:0]  res_grant_reg, res_grant_next;
    logic               out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]  out_status_reg, out_status_next;
    logic [ADDR_W-1:0]  out_grant_reg, out_grant_next;
    logic [ADDR_W-1:0]  base_reg;
    logic [TOP_W-1:0]   top_reg;
    logic [CW-1:0]      counts_reg [NORD];

    logic               cfg_base_wr, cfg_size_wr;
    logic [TOP_W-1:0]   new_top;
    logic [ORD_W-1:0]   sel_ord;
    logic               sel_ok;
    logic [CW-1:0]      cnt_rd;
    logic [AW-1:0]      sel_base;
    logic               cnt_we;
    logic [CW-1:0]      cnt_wd;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic [IDX_W-1:0]   mem_wdata, mem_rdata;
    logic [IDX_W-1:0]   buddy;
    logic [ORD_W-1:0]   want_c;
    logic [ADDR_W-1:0]  off;
    logic [ORD_W-1:0]   top_ext;

    assign cfg_base_wr = cfg_we && (cfg_index == CFG_REGION_BASE);
    assign cfg_size_wr = cfg_we && (cfg_index == CFG_REGION_BYTES);
    assign new_top     = floor_log2(cfg_data[SIZE_W-1:0]);
    assign top_ext     = ORD_W'(top_reg);

    // split pushes into the order below the current one
    assign sel_ord  = (state_reg == S_ASPLIT) ? ord_reg - ORD_W'(1) : ord_reg;
    assign sel_ok   = (sel_ord <= ORD_W'(REGION_ORDER));
    assign cnt_rd   = sel_ok ? counts_reg[sel_ord[OW-1:0]] : '0;
    assign sel_base = slice_of(sel_ord);
    assign buddy    = idx_reg ^ (IDX_W'(1) << (ord_reg - ORD_W'(MIN_ORDER)));
    assign want_c   = order_of(bytes_reg);
    assign off      = addr_reg - base_reg;

    bba_store #(
        .AW (AW),
        .DW (IDX_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        bytes_next      = bytes_reg;
        addr_next       = addr_reg;
        want_next       = want_reg;
        ord_next        = ord_reg;
        idx_next        = idx_reg;
        ptr_next        = ptr_reg;
        res_status_next = res_status_reg;
        res_grant_next  = res_grant_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_grant_next  = out_grant_reg;
        cnt_we          = 1'b0;
        cnt_wd          = cnt_rd;
        mem_we          = 1'b0;
        mem_waddr       = sel_base + cnt_rd;
        mem_wdata       = idx_reg;
        mem_raddr       = sel_base + ptr_reg;

        unique case (state_reg)
            S_INIT:
            begin
                if (!cfg_size_wr && (TOP_RST >= MIN_ORDER))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = slice_of(ORD_W'(TOP_RST));
                    mem_wdata = '0;
                end
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.opcode;
                    bytes_next = req.request_bytes;
                    addr_next  = req.block_address;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                want_next = want_c;
                ord_next  = want_c;
                if (op_reg == OP_ALLOC)
                begin
                    if (base_reg == '0 || bytes_reg == '0)
                    begin
                        res_status_next = ST_REFUSED;
                        res_grant_next  = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_ASCAN;
                    end
                end
                else
                begin
                    if (bytes_reg == '0 || addr_reg == '0 || (off & LOW_MASK) != '0
                        || (off >> top_reg) != '0)
                    begin
                        res_status_next = ST_IGNORED;
                        res_grant_next  = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        idx_next   = IDX_W'(off >> MIN_ORDER);
                        state_next = S_FCHK;
                    end
                end
            end
            S_ASCAN:
            begin
                if (ord_reg > top_ext)
                begin
                    res_status_next = ST_REFUSED;
                    res_grant_next  = '0;
                    state_next      = S_DONE;
                end
                else if (cnt_rd != '0)
                begin
                    cnt_we     = 1'b1;
                    cnt_wd     = cnt_rd - CW'(1);
                    ptr_next   = cnt_rd - CW'(1);
                    state_next = S_APOP;
                end
                else
                begin
                    ord_next = ord_reg + ORD_W'(1);
                end
            end
            S_APOP:
            begin
                state_next = S_AGET;
            end
            S_AGET:
            begin
                idx_next   = mem_rdata;
                state_next = S_ASPLIT;
            end
            S_ASPLIT:
            begin
                if (ord_reg > want_reg)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = idx_reg + (IDX_W'(1) << (sel_ord - ORD_W'(MIN_ORDER)));
                    cnt_we    = 1'b1;
                    cnt_wd    = cnt_rd + CW'(1);
                    ord_next  = sel_ord;
                end
                else
                begin
                    res_status_next = ST_DONE;
                    res_grant_next  = base_reg + (ADDR_W'(idx_reg) << MIN_ORDER);
                    state_next      = S_DONE;
                end
            end
            S_FCHK:
            begin
                if (ord_reg < top_ext && cnt_rd != '0)
                begin
                    ptr_next   = cnt_rd - CW'(1);
                    state_next = S_FSRCH;
                end
                else
                begin
                    state_next = S_FEND;
                end
            end
            S_FSRCH:
            begin
                state_next = S_FCMP;
            end
            S_FCMP:
            begin
                if (mem_rdata == buddy)
                begin
                    if ((CW+1)'(ptr_reg) + (CW+1)'(1) < (CW+1)'(cnt_rd))
                    begin
                        state_next = S_FSHR;
                    end
                    else
                    begin
                        cnt_we     = 1'b1;
                        cnt_wd     = cnt_rd - CW'(1);
                        idx_next   = (buddy < idx_reg) ? buddy : idx_reg;
                        ord_next   = ord_reg + ORD_W'(1);
                        state_next = S_FCHK;
                    end
                end
                else if (ptr_reg == '0)
                begin
                    state_next = S_FEND;
                end
                else
                begin
                    ptr_next   = ptr_reg - CW'(1);
                    state_next = S_FSRCH;
                end
            end
            S_FSHR:
            begin
                mem_raddr  = sel_base + ptr_reg + AW'(1);
                state_next = S_FSHW;
            end
            S_FSHW:
            begin
                mem_we    = 1'b1;
                mem_waddr = sel_base + ptr_reg;
                mem_wdata = mem_rdata;
                if ((CW+1)'(ptr_reg) + (CW+1)'(2) < (CW+1)'(cnt_rd))
                begin
                    ptr_next   = ptr_reg + CW'(1);
                    state_next = S_FSHR;
                end
                else
                begin
                    cnt_we     = 1'b1;
                    cnt_wd     = cnt_rd - CW'(1);
                    idx_next   = (buddy < idx_reg) ? buddy : idx_reg;
                    ord_next   = ord_reg + ORD_W'(1);
                    state_next = S_FCHK;
                end
            end
            S_FEND:
            begin
                res_grant_next = '0;
                if (!sel_ok || (CW+1)'(cnt_rd) >= cap_of(ord_reg))
                begin
                    res_status_next = ST_OVERFLOW;
                end
                else
                begin
                    mem_we          = 1'b1;
                    cnt_we          = 1'b1;
                    cnt_wd          = cnt_rd + CW'(1);
                    res_status_next = ST_DONE;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_grant_next  = res_grant_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // reseed on a size write; user writes it only when idle, unchecked
        if (cfg_size_wr && new_top >= TOP_W'(MIN_ORDER))
        begin
            mem_we    = 1'b1;
            mem_waddr = slice_of(ORD_W'(new_top));
            mem_wdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
            base_reg      <= '0;
            top_reg       <= TOP_W'(TOP_RST);
            for (int i = 0; i < NORD; i++)
            begin
                counts_reg[i] <= (i == TOP_RST && TOP_RST >= MIN_ORDER) ? CW'(1) : '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_base_wr)
            begin
                base_reg <= cfg_data[ADDR_W-1:0];
            end
            if (cfg_size_wr)
            begin
                top_reg <= new_top;
                for (int i = 0; i < NORD; i++)
                begin
                    counts_reg[i] <= (TOP_W'(i) == new_top && i >= MIN_ORDER) ? CW'(1) : '0;
                end
            end
            else if (cnt_we)
            begin
                counts_reg[sel_ord[OW-1:0]] <= cnt_wd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        bytes_reg      <= bytes_next;
        addr_reg       <= addr_next;
        want_reg       <= want_next;
        ord_reg        <= ord_next;
        idx_reg        <= idx_next;
        ptr_reg        <= ptr_next;
        res_status_reg <= res_status_next;
        res_grant_reg  <= res_grant_next;
        out_status_reg <= out_status_next;
        out_grant_reg  <= out_grant_next;
    end

    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.granted_address = out_grant_reg;

endmodule

### rtl/core/bba_checker.sv
module bba_checker
    import bba_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [STAT_W-1:0] status,
    input logic [ADDR_W-1:0] granted_address
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(granted_address))
        else $error("result dropped or changed while stalled");

    // only a successful allocation carries an address
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_DONE |-> granted_address == '0)
        else $error("address on refused or ignored item");

    // one item in flight: busy right after an input transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while one in flight");

endmodule

bind buddy_block_allocator_unit bba_checker u_bba_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (req.valid),
    .in_ready        (req.ready),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .status          (rsp.status),
    .granted_address (rsp.granted_address)
);

### test/tb_top.sv
module tb_top;
    import bba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int REG_ORD = 20;
    localparam int MIN_ORD = 6;

    typedef struct packed {
        logic               op;
        logic [BYTES_W-1:0] bytes;
        logic [ADDR_W-1:0]  addr;
    } alloc_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] granted;
    } alloc_rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [BYTES_W-1:0] bytes;
    } live_blk_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               drv_valid = 1'b0;
    logic               drv_op    = 1'b0;
    logic [BYTES_W-1:0] drv_bytes = '0;
    logic [ADDR_W-1:0]  drv_addr  = '0;
    logic               rcv_ready = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data  = '0;

    bba_req_if req_ch ();
    bba_rsp_if rsp_ch ();

    assign req_ch.valid         = drv_valid;
    assign req_ch.opcode        = drv_op;
    assign req_ch.request_bytes = drv_bytes;
    assign req_ch.block_address = drv_addr;
    assign rsp_ch.ready         = rcv_ready;

    buddy_block_allocator_unit #(
        .REGION_ORDER (REG_ORD),
        .MIN_ORDER    (MIN_ORD)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow allocator state
    logic [13:0]       free_stk [REG_ORD+1][$];
    int unsigned       top_ord;
    logic [ADDR_W-1:0] shadow_base;

    alloc_req_t  pending_reqs [$];
    alloc_rsp_t  expected_rsps [$];
    live_blk_t   live_blocks [$];

    int send_idle = 0;
    int recv_idle = 0;
    int errors = 0;
    int n_grant = 0, n_refuse = 0, n_ignore = 0, n_ovf = 0;
    int n_accepted = 0;
    logic hold_req = 1'b0;
    int   hold_cnt = 0;

    function automatic int unsigned size_order(logic [BYTES_W-1:0] b);
        int unsigned k = MIN_ORD;
        while (((64'd1 << k) < {32'd0, b}) && k < 32)
            k++;
        return k;
    endfunction

    function automatic longint unsigned stack_cap(int unsigned k);
        return 64'd1 << (REG_ORD - k);
    endfunction

    function automatic void reseed_shadow(logic [SIZE_W-1:0] v);
        int unsigned k = 0;
        while (k < 63 && ({43'd0, v} >> (k + 1)) != 0)
            k++;
        if (k > REG_ORD)
            k = REG_ORD;
        top_ord = k;
        for (int i = 0; i <= REG_ORD; i++)
            free_stk[i].delete();
        if (top_ord >= MIN_ORD)
            free_stk[top_ord].push_back(14'd0);
    endfunction

    // remove newest matching entry, keeping the rest in order
    function automatic bit take_buddy(int unsigned k, logic [13:0] idx);
        for (int i = free_stk[k].size() - 1; i >= 0; i--)
            if (free_stk[k][i] == idx)
            begin
                free_stk[k].delete(i);
                return 1'b1;
            end
        return 1'b0;
    endfunction

    function automatic alloc_rsp_t predict_alloc(alloc_req_t it);
        alloc_rsp_t  r;
        int unsigned want, have;
        logic [13:0] idx;
        logic [ADDR_W-1:0] off;
        logic [13:0] buddy;
        r.status  = ST_DONE;
        r.granted = '0;
        if (it.op == OP_ALLOC)
        begin
            if (shadow_base == 0 || it.bytes == 0)
                r.status = ST_REFUSED;
            else
            begin
                want = size_order(it.bytes);
                have = want;
                while (have <= top_ord && free_stk[have].size() == 0)
                    have++;
                // orders below the first non-empty one are empty, so a split always has room
                if (want > top_ord || have > top_ord)
                    r.status = ST_REFUSED;
                else
                begin
                    idx = free_stk[have].pop_back();
                    while (have > want)
                    begin
                        have--;
                        free_stk[have].push_back(idx + 14'(1 << (have - MIN_ORD)));
                    end
                    r.granted = shadow_base + ({34'd0, idx} << MIN_ORD);
                    live_blocks.push_back('{r.granted, it.bytes});
                end
            end
        end
        else
        begin
            off = it.addr - shadow_base;
            if (it.bytes == 0 || it.addr == 0 || off[MIN_ORD-1:0] != 0
                || {16'd0, off} >= (64'd1 << top_ord))
                r.status = ST_IGNORED;
            else
            begin
                idx  = 14'(off >> MIN_ORD);
                have = size_order(it.bytes);
                while (have < top_ord)
                begin
                    buddy = idx ^ 14'(1 << (have - MIN_ORD));
                    if (!take_buddy(have, buddy))
                        break;
                    if (buddy < idx)
                        idx = buddy;
                    have++;
                end
                if (have > REG_ORD)
                    r.status = ST_OVERFLOW;
                else if (free_stk[have].size() >= stack_cap(have))
                    r.status = ST_OVERFLOW;
                else
                    free_stk[have].push_back(idx);
            end
        end
        return r;
    endfunction

    // driver
    always @(posedge clk)
    begin
        alloc_req_t it;
        if (rst_n && (!drv_valid || req_ch.ready))
        begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                it = pending_reqs.pop_front();
                drv_valid <= 1'b1;
                drv_op    <= it.op;
                drv_bytes <= it.bytes;
                drv_addr  <= it.addr;
            end
            else
                drv_valid <= 1'b0;
        end
    end

    // predict on each accepted transfer
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            expected_rsps.push_back(predict_alloc('{req_ch.opcode, req_ch.request_bytes,
                                                     req_ch.block_address}));
            n_accepted++;
        end
    end

    always @(posedge clk)
    begin
        if (hold_req)
            hold_cnt <= 600;
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            rcv_ready <= 1'b0;
        else if (hold_cnt != 0)
            rcv_ready <= 1'b0;
        else
            rcv_ready <= ($urandom_range(99) >= recv_idle);
    end

    // monitor
    always @(posedge clk)
    begin
        alloc_rsp_t e;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: status %0d addr %h", rsp_ch.status,
                             rsp_ch.granted_address);
            end
            else
            begin
                e = expected_rsps.pop_front();
                case (e.status)
                    ST_DONE:     n_grant++;
                    ST_REFUSED:  n_refuse++;
                    ST_IGNORED:  n_ignore++;
                    default:     n_ovf++;
                endcase
                if (rsp_ch.status !== e.status || rsp_ch.granted_address !== e.granted)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected status %0d addr %h, got status %0d addr %h",
                                 e.status, e.granted, rsp_ch.status, rsp_ch.granted_address);
                end
            end
        end
    end

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || drv_valid)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_REGION_BASE)
            shadow_base = val[ADDR_W-1:0];
        else
            reseed_shadow(val[SIZE_W-1:0]);
        live_blocks.delete();
    endtask

    task automatic push_req(logic op, logic [BYTES_W-1:0] b, logic [ADDR_W-1:0] a);
        pending_reqs.push_back('{op, b, a});
    endtask

    function automatic logic [ADDR_W-1:0] rand48();
        return ADDR_W'({$urandom(), $urandom()});
    endfunction

    task automatic random_phase(int n);
        int          pick;
        live_blk_t   lb;
        logic [BYTES_W-1:0] b;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
                push_req(1'($urandom_range(1)), $urandom(), rand48());
            else if (pick < 16)
                push_req(OP_FREE, $urandom_range(1, 4096),
                         shadow_base + (ADDR_W'($urandom()) & 48'hFFFC0));
            else if (pick < 55 || live_blocks.size() == 0)
            begin
                if ($urandom_range(9) == 0)
                    b = $urandom_range(1, 1 << 20);
                else
                    b = $urandom_range(1, 2048);
                push_req(OP_ALLOC, b, rand48());
            end
            else
            begin
                pick = $urandom_range(live_blocks.size() - 1);
                lb = live_blocks[pick];
                live_blocks.delete(pick);
                push_req(OP_FREE, lb.bytes, lb.addr);
            end
            // short batches so frees can follow the grants they release
            if (i % 8 == 7)
                while (pending_reqs.size() != 0 || expected_rsps.size() > 2)
                    @(posedge clk);
        end
    endtask

    initial
    begin
        logic [ADDR_W-1:0] bases [6];
        logic [CFG_W-1:0]  sizes [6];
        shadow_base = '0;
        reseed_shadow(21'd1048576);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // no region after reset
        push_req(OP_ALLOC, 32'd64, '0);
        wait_idle();
        write_reg(CFG_REGION_BASE, 48'h1000);
        write_reg(CFG_REGION_BYTES, 48'd1048576);
        push_req(OP_ALLOC, 32'd0, '0);
        push_req(OP_ALLOC, 32'hFFFF_FFFF, '0);
        push_req(OP_ALLOC, 32'd1, '0);
        push_req(OP_ALLOC, 32'd100, 48'hFFFF_FFFF_FFFF);
        push_req(OP_ALLOC, 32'd1048576, '0);
        push_req(OP_FREE, 32'd0, 48'h1000);
        push_req(OP_FREE, 32'd64, 48'h0);
        push_req(OP_FREE, 32'd64, 48'h1001);
        push_req(OP_FREE, 32'd64, 48'h1000 + 48'h100000);
        push_req(OP_FREE, 32'hFFFF_FFFF, 48'h1000);
        push_req(OP_FREE, 32'd64, 48'h1000);
        push_req(OP_FREE, 32'd64, 48'h1000);
        push_req(OP_FREE, 32'd128, 48'h1040);
        push_req(OP_FREE, 32'd2097152, 48'h1000);
        push_req(OP_FREE, 32'd1048576, 48'h1000);
        push_req(OP_FREE, 32'd1048576, 48'h1000);
        push_req(OP_ALLOC, 32'd65, '0);
        push_req(OP_ALLOC, 32'd524288, '0);
        wait_idle();
        write_reg(CFG_REGION_BYTES, 48'd32);
        push_req(OP_ALLOC, 32'd1, '0);
        push_req(OP_FREE, 32'd64, 48'h1000);
        push_req(OP_ALLOC, 32'd64, '0);
        wait_idle();

        bases = '{48'hFFFF_FFF0_0000, 48'h0000_0040_0000, 48'h1234_5678_9AC0,
                  48'hABCD_0000_0000, 48'h0000_0000_0040, 48'hFFFF_FFFF_FFFF};
        sizes = '{48'd1048576, 48'd8192, 48'h1F_FFFF, 48'd0, 48'd100, 48'd1048576};
        bases[2] = rand48() | 48'h40;
        for (int p = 0; p < 6; p++)
        begin
            case (p % 3)
                0:       begin send_idle = 25; recv_idle = 80; end
                1:       begin send_idle = 80; recv_idle = 25; end
                default: begin send_idle = 0;  recv_idle = 0;  end
            endcase
            write_reg(CFG_REGION_BASE, bases[p]);
            write_reg(CFG_REGION_BYTES, sizes[p]);
            if (p == 2)
            begin
                @(posedge clk) hold_req <= 1'b1;
                @(posedge clk) hold_req <= 1'b0;
            end
            random_phase(190);
            wait_idle();
        end

        repeat (50) @(posedge clk);
        $display("%0d requests: %0d grants or frees done, %0d refused, %0d ignored, %0d overflow",
                 n_accepted, n_grant, n_refuse, n_ignore, n_ovf);
        $display("nine region settings incl. no region, tiny, wrapping base; one long stall");
        if (errors == 0 && expected_rsps.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
